// File: rtl/lpbrc_pkg.sv
// ----------------------------------------------------------------------------
// lpbrc_pkg: shared types and constants for the best-result cache
// Key width, default sizing, request function codes and response status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lpbrc_pkg;

   localparam int KEY_W                 = 64;
   localparam int DEFAULT_TABLE_DEPTH   = 256;
   localparam int DEFAULT_PAYLOAD_WIDTH = 32;
   localparam int DEFAULT_TIME_WIDTH    = 32;
   localparam int STATUS_W              = 3;

   typedef enum logic {
      FUNC_LOOKUP = 1'b0,
      FUNC_STORE  = 1'b1
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_FOUND    = 3'd0,
      STATUS_MISS     = 3'd1,
      STATUS_INSERTED = 3'd2,
      STATUS_IMPROVED = 3'd3,
      STATUS_KEPT     = 3'd4,
      STATUS_FULL     = 3'd5
   } status_type;

endpackage

`default_nettype wire

// File: rtl/linear_probe_best_result_cache_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_best_result_cache_unit: best-result hash cache
// Open-addressing table with linear probing, keeps the smallest time per key.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one response
// follows, shown for one cycle with rsp_strobe, and the receiver cannot stall
// it. After reset the unit sweeps the slot RAM, one slot per cycle, holding
// busy high until the sweep ends. A request then forms the home slot and
// probes from it, one read of the slot RAM's read port per probe, up to
// TABLE_DEPTH slots in all; the response cycle overlaps the next acceptance.
// With a depth that is not a power of two the home slot is reduced four key
// bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_best_result_cache_unit #(
   parameter int TABLE_DEPTH   = lpbrc_pkg::DEFAULT_TABLE_DEPTH,
   parameter int PAYLOAD_WIDTH = lpbrc_pkg::DEFAULT_PAYLOAD_WIDTH,
   parameter int TIME_WIDTH    = lpbrc_pkg::DEFAULT_TIME_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_func,
   input  wire logic [lpbrc_pkg::KEY_W-1:0]         req_key,
   input  wire logic [PAYLOAD_WIDTH-1:0]            req_payload_in,
   input  wire logic [TIME_WIDTH-1:0]               req_time_in,
   output logic                                     rsp_strobe,
   output logic      [lpbrc_pkg::STATUS_W-1:0]      rsp_status,
   output logic      [PAYLOAD_WIDTH-1:0]            rsp_payload_out,
   output logic      [TIME_WIDTH-1:0]               rsp_time_out,
   output logic      [$clog2(TABLE_DEPTH+1)-1:0]    rsp_entry_total
);

   import lpbrc_pkg::*;

   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int ENTRY_W = $clog2(TABLE_DEPTH + 1);
   localparam int WORD_W  = 1 + KEY_W + PAYLOAD_WIDTH + TIME_WIDTH;
   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(TABLE_DEPTH - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HOME,
      ST_PROBE
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0]  probes_ff, probes_in;
   logic [ENTRY_W-1:0] occupied_ff, occupied_in;
   func_type           func_ff, func_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [PAYLOAD_WIDTH-1:0] pay_ff, pay_in;
   logic [TIME_WIDTH-1:0]    time_ff, time_in;

   logic                     strobe_ff, strobe_in;
   status_type               status_ff, status_in;
   logic [PAYLOAD_WIDTH-1:0] pay_out_ff, pay_out_in;
   logic [TIME_WIDTH-1:0]    time_out_ff, time_out_in;

   logic               accept;
   logic [ADDR_W-1:0]  home;
   logic               home_done;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [WORD_W-1:0]  rd_data;

   logic                     slot_valid;
   logic [KEY_W-1:0]         slot_key;
   logic [PAYLOAD_WIDTH-1:0] slot_pay;
   logic [TIME_WIDTH-1:0]    slot_time;
   logic [ADDR_W-1:0]        idx_next;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   assign slot_time  = rd_data[TIME_WIDTH-1:0];
   assign slot_pay   = rd_data[TIME_WIDTH +: PAYLOAD_WIDTH];
   assign slot_key   = rd_data[TIME_WIDTH + PAYLOAD_WIDTH +: KEY_W];
   assign slot_valid = rd_data[WORD_W-1];

   assign idx_next = (idx_ff == LAST_SLOT) ? '0 : idx_ff + ADDR_W'(1);

   lpbrc_home_unit #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_home (
      .clock (clock),
      .reset (reset),
      .load  (accept),
      .key   (req_key),
      .home  (home),
      .done  (home_done)
   );

   lpbrc_slot_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (WORD_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      probes_in   = probes_ff;
      occupied_in = occupied_ff;
      func_in     = func_ff;
      key_in      = key_ff;
      pay_in      = pay_ff;
      time_in     = time_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      pay_out_in  = pay_out_ff;
      time_out_in = time_out_ff;

      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = {1'b1, key_ff, pay_ff, time_ff};
      rd_addr = idx_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            idx_in  = idx_next;
            if (idx_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               func_in  = func_type'(req_func);
               key_in   = req_key;
               pay_in   = req_payload_in;
               time_in  = req_time_in;
               state_in = ST_HOME;
            end
         end

         ST_HOME: begin
            rd_addr = home;
            if (home_done) begin
               idx_in    = home;
               probes_in = '0;
               state_in  = ST_PROBE;
            end
         end

         ST_PROBE: begin
            pay_out_in  = '0;
            time_out_in = '0;
            priority if (!slot_valid) begin
               if (func_ff == FUNC_STORE) begin
                  wr_en     = 1'b1;
                  status_in = STATUS_INSERTED;
                  if (occupied_ff < ENTRY_W'(TABLE_DEPTH)) begin
                     occupied_in = occupied_ff + ENTRY_W'(1);
                  end
               end else begin
                  status_in = STATUS_MISS;
               end
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else if (slot_key == key_ff) begin
               if (func_ff == FUNC_STORE) begin
                  if (time_ff < slot_time) begin
                     wr_en     = 1'b1;
                     status_in = STATUS_IMPROVED;
                  end else begin
                     status_in = STATUS_KEPT;
                  end
               end else begin
                  status_in   = STATUS_FOUND;
                  pay_out_in  = slot_pay;
                  time_out_in = slot_time;
               end
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else if (probes_ff == LAST_SLOT) begin
               // full pass without a match or a free slot
               status_in = (func_ff == FUNC_STORE) ? STATUS_FULL : STATUS_MISS;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               rd_addr   = idx_next;
               idx_in    = idx_next;
               probes_in = probes_ff + ADDR_W'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         idx_ff      <= '0;
         probes_ff   <= '0;
         occupied_ff <= '0;
         strobe_ff   <= 1'b0;
         func_ff     <= FUNC_LOOKUP;
         status_ff   <= STATUS_MISS;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         probes_ff   <= probes_in;
         occupied_ff <= occupied_in;
         strobe_ff   <= strobe_in;
         func_ff     <= func_in;
         status_ff   <= status_in;
      end
      key_ff      <= key_in;
      pay_ff      <= pay_in;
      time_ff     <= time_in;
      pay_out_ff  <= pay_out_in;
      time_out_ff <= time_out_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_payload_out = pay_out_ff;
   assign rsp_time_out    = time_out_ff;
   assign rsp_entry_total = occupied_ff;

endmodule

`default_nettype wire

// File: rtl/lpbrc_slot_ram.sv
// ----------------------------------------------------------------------------
// lpbrc_slot_ram: slot storage
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbrc_slot_ram #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 129
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/lpbrc_home_unit.sv
// ----------------------------------------------------------------------------
// lpbrc_home_unit: home slot computation
// key mod TABLE_DEPTH. A power-of-two depth registers the low key bits
// directly; any other depth folds the key in four bits per cycle, MSB first,
// and brings the running remainder back below the depth by comparing it
// against all fifteen multiples of the depth side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbrc_home_unit #(
   parameter int TABLE_DEPTH = lpbrc_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               load,
   input  wire logic [lpbrc_pkg::KEY_W-1:0]        key,
   output logic      [$clog2(TABLE_DEPTH)-1:0]     home,
   output logic                                    done
);

   import lpbrc_pkg::*;

   localparam int  ADDR_W   = $clog2(TABLE_DEPTH);
   localparam int  DIGIT_W  = 4;
   localparam int  DIGITS   = KEY_W / DIGIT_W;
   localparam int  CNT_W    = $clog2(DIGITS);
   localparam int  TRIAL_W  = ADDR_W + DIGIT_W;
   localparam bit  POW2     = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

   logic [KEY_W-1:0]   shift_ff, shift_in;
   logic [ADDR_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [TRIAL_W-1:0] trial;
   logic [TRIAL_W-1:0] reduced;

   always_comb begin
      // trial stays below 16 * depth, so one of the multiples brings it under the depth
      trial   = {rem_ff, shift_ff[KEY_W-1 -: DIGIT_W]};
      reduced = trial;
      for (int k = 1; k < (1 << DIGIT_W); k++) begin
         if (trial >= TRIAL_W'(k * TABLE_DEPTH)) begin
            reduced = trial - TRIAL_W'(k * TABLE_DEPTH);
         end
      end

      shift_in = shift_ff << DIGIT_W;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;

      if (load) begin
         if (POW2) begin
            rem_in  = key[ADDR_W-1:0];
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            shift_in = key;
            rem_in   = '0;
            cnt_in   = '0;
            run_in   = 1'b1;
         end
      end else if (run_ff) begin
         // remainder stays below the depth, so it fits the address width
         rem_in = reduced[ADDR_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIGITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign home = rem_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

// File: test/linear_probe_best_result_cache_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_best_result_cache_unit_tb: self-checking bench for the cache
// Drives lookup and store requests with random spacing. A shadow copy of the
// slot table works out each response, and the monitor checks every strobed
// response against the oldest pending prediction. The run starts with a short
// directed sequence (hits, misses, improve/keep, wrap-around probes). It then
// runs a random mix that fills the table to full and keeps going on the full
// table.
// ----------------------------------------------------------------------------

module linear_probe_best_result_cache_unit_tb;

   import lpbrc_pkg::*;

   localparam int DEPTH           = DEFAULT_TABLE_DEPTH;
   localparam int PAY_W           = DEFAULT_PAYLOAD_WIDTH;
   localparam int COST_W          = DEFAULT_TIME_WIDTH;
   localparam int TOTAL_W         = $clog2(DEPTH + 1);
   localparam int RANDOM_REQUESTS = 2000;
   localparam int DRAIN_CYCLES    = 2 * DEPTH + 50;
   localparam int CYCLE_LIMIT     = 4_000_000;

   typedef struct packed {
      func_type            func;
      logic [KEY_W-1:0]    key;
      logic [PAY_W-1:0]    payload;
      logic [COST_W-1:0]   cost;
   } cache_request_type;

   typedef struct packed {
      status_type          status;
      logic [PAY_W-1:0]    payload;
      logic [COST_W-1:0]   cost;
      logic [TOTAL_W-1:0]  total;
   } cache_response_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_func = 1'b0;
   logic [KEY_W-1:0]      req_key = '0;
   logic [PAY_W-1:0]      req_payload_in = '0;
   logic [COST_W-1:0]     req_time_in = '0;
   logic                  rsp_strobe;
   logic [STATUS_W-1:0]   rsp_status;
   logic [PAY_W-1:0]      rsp_payload_out;
   logic [COST_W-1:0]     rsp_time_out;
   logic [TOTAL_W-1:0]    rsp_entry_total;

   // shadow of the slot table
   bit                    slot_used [DEPTH];
   logic [KEY_W-1:0]      slot_key [DEPTH];
   logic [PAY_W-1:0]      slot_payload [DEPTH];
   logic [COST_W-1:0]     slot_cost [DEPTH];
   int                    occupied = 0;

   cache_request_type     request_backlog [$];
   cache_response_type    expected_responses [$];
   cache_request_type     next_req;
   cache_request_type     taken_req;
   cache_response_type    seen_rsp;
   cache_response_type    want_rsp;
   int                    issued_total = 0;
   int                    accepted_total = 0;
   int                    response_index = 0;
   int                    mismatch_count = 0;
   int                    gap_left = 0;
   int                    calm_left = 0;
   int                    cycle_count = 0;

   linear_probe_best_result_cache_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_key         (req_key),
      .req_payload_in  (req_payload_in),
      .req_time_in     (req_time_in),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_payload_out (rsp_payload_out),
      .rsp_time_out    (rsp_time_out),
      .rsp_entry_total (rsp_entry_total)
   );

   always #1 clock = ~clock;

   // Walks the shadow table from the home slot and applies the request.
   function automatic cache_response_type probe_table(cache_request_type rq);
      cache_response_type rs;
      int home;
      int idx;
      bit done;
      if (rq.func == FUNC_STORE) begin
         rs.status = STATUS_FULL;
      end else begin
         rs.status = STATUS_MISS;
      end
      rs.payload = '0;
      rs.cost = '0;
      done = 1'b0;
      home = int'(rq.key % DEPTH);
      for (int n = 0; n < DEPTH && !done; n++) begin
         idx = (home + n) % DEPTH;
         if (!slot_used[idx]) begin
            if (rq.func == FUNC_STORE) begin
               slot_used[idx] = 1'b1;
               slot_key[idx] = rq.key;
               slot_payload[idx] = rq.payload;
               slot_cost[idx] = rq.cost;
               occupied++;
               rs.status = STATUS_INSERTED;
            end else begin
               rs.status = STATUS_MISS;
            end
            done = 1'b1;
         end else if (slot_key[idx] == rq.key) begin
            if (rq.func == FUNC_STORE) begin
               // strictly smaller wins; a tie keeps the older entry
               if (rq.cost < slot_cost[idx]) begin
                  slot_payload[idx] = rq.payload;
                  slot_cost[idx] = rq.cost;
                  rs.status = STATUS_IMPROVED;
               end else begin
                  rs.status = STATUS_KEPT;
               end
            end else begin
               rs.status = STATUS_FOUND;
               rs.payload = slot_payload[idx];
               rs.cost = slot_cost[idx];
            end
            done = 1'b1;
         end
      end
      rs.total = TOTAL_W'(occupied);
      return rs;
   endfunction

   task automatic queue_request(func_type func, logic [KEY_W-1:0] key,
                                logic [PAY_W-1:0] payload, logic [COST_W-1:0] cost);
      cache_request_type rq;
      rq.func = func;
      rq.key = key;
      rq.payload = payload;
      rq.cost = cost;
      request_backlog.push_back(rq);
      issued_total++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
         calm_left <= 0;
      end else begin
         if (start && !busy) begin
            taken_req.func = func_type'(req_func);
            taken_req.key = req_key;
            taken_req.payload = req_payload_in;
            taken_req.cost = req_time_in;
            expected_responses.push_back(probe_table(taken_req));
            accepted_total++;
         end
         if (start && busy) begin
            // request still waiting to be taken
         end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (request_backlog.size() > 0) begin
            next_req = request_backlog.pop_front();
            req_func <= next_req.func;
            req_key <= next_req.key;
            req_payload_in <= next_req.payload;
            req_time_in <= next_req.cost;
            start <= 1'b1;
            if (calm_left > 0) begin
               gap_left <= 0;
               calm_left <= calm_left - 1;
            end else begin
               gap_left <= $urandom_range(0, 12);
               if ($urandom_range(0, 29) == 0) begin
                  calm_left <= $urandom_range(10, 40);
               end
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         seen_rsp.status = status_type'(rsp_status);
         seen_rsp.payload = rsp_payload_out;
         seen_rsp.cost = rsp_time_out;
         seen_rsp.total = rsp_entry_total;
         if (expected_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("ERROR: response %0d with no request pending: status %0d",
                        response_index, rsp_status);
            end
         end else begin
            want_rsp = expected_responses.pop_front();
            if (seen_rsp !== want_rsp) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("ERROR: response %0d exp status %0d pay %h time %h total %0d",
                           response_index, want_rsp.status, want_rsp.payload,
                           want_rsp.cost, want_rsp.total);
                  $display("       got status %0d pay %h time %h total %0d",
                           rsp_status, rsp_payload_out, rsp_time_out, rsp_entry_total);
               end
            end
         end
         response_index++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      logic [KEY_W-1:0]  known_keys [$];
      logic [KEY_W-1:0]  key;
      logic [COST_W-1:0] cost;
      int                pick;

      // directed: empty table, extremes, equal/smaller/larger times, wrap at slot 255
      queue_request(FUNC_LOOKUP, 64'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_request(FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0);
      queue_request(FUNC_STORE, 64'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_request(FUNC_LOOKUP, 64'h0, 32'h0, 32'h0);
      queue_request(FUNC_STORE, 64'h0, 32'h1234_5678, 32'hFFFF_FFFF);
      queue_request(FUNC_STORE, 64'h0, 32'h0, 32'h0000_0100);
      queue_request(FUNC_STORE, 64'h0, 32'h1111_1111, 32'h0000_0200);
      queue_request(FUNC_LOOKUP, 64'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_request(FUNC_STORE, 64'h100, 32'hDEAD_BEEF, 32'h0001_0000);
      queue_request(FUNC_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0);
      queue_request(FUNC_STORE, 64'h1FF, 32'hCAFE_F00D, 32'h8000_0000);
      queue_request(FUNC_LOOKUP, 64'h1FF, 32'h0, 32'h0);
      queue_request(FUNC_LOOKUP, 64'h2FF, 32'h0, 32'h0);
      queue_request(FUNC_STORE, 64'h1FF, 32'h0BAD_CAFE, 32'h0);
      queue_request(FUNC_STORE, 64'h1FF, 32'h7777_7777, 32'h0);
      queue_request(FUNC_LOOKUP, 64'h1FF, 32'h0, 32'h0);
      queue_request(FUNC_LOOKUP, 64'h100, 32'h0, 32'h0);
      queue_request(FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0);
      queue_request(FUNC_STORE, 64'h8000_0000_0000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
      queue_request(FUNC_LOOKUP, 64'h8000_0000_0000_0000, 32'h0, 32'h0);
      queue_request(FUNC_STORE, 64'h7FFF_FFFF_FFFF_FFFF, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
      queue_request(FUNC_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0, 32'h0);
      known_keys.push_back(64'h0);
      known_keys.push_back(64'h100);
      known_keys.push_back(64'hFFFF_FFFF_FFFF_FFFF);
      known_keys.push_back(64'h1FF);
      known_keys.push_back(64'h8000_0000_0000_0000);
      known_keys.push_back(64'h7FFF_FFFF_FFFF_FFFF);

      // random mix; fresh stores fill the table part way through, so the
      // tail runs against a full table (full passes, table full)
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         pick = $urandom_range(0, 99);
         key = {$urandom, $urandom};
         // half the fresh keys crowd the slots around the wrap point
         if ($urandom_range(0, 1) == 1) begin
            key[7:0] = 8'(8'hF0 + $urandom_range(0, 31));
         end
         case ($urandom_range(0, 3))
            0: cost = $urandom_range(0, 3);
            1: cost = 32'hFFFF_FFFF;
            2: cost = $urandom_range(0, 255);
            default: cost = $urandom;
         endcase
         if (pick < 30) begin
            queue_request(FUNC_LOOKUP, known_keys[$urandom_range(0, known_keys.size() - 1)],
                          $urandom, $urandom);
         end else if (pick < 40) begin
            queue_request(FUNC_LOOKUP, key, $urandom, $urandom);
         end else if (pick < 70) begin
            queue_request(FUNC_STORE, known_keys[$urandom_range(0, known_keys.size() - 1)],
                          $urandom, cost);
         end else begin
            // below 78: same home as a known key but different upper bits
            if (pick < 78) begin
               key[7:0] = known_keys[$urandom_range(0, known_keys.size() - 1)][7:0];
            end
            queue_request(FUNC_STORE, key, $urandom, cost);
            known_keys.push_back(key);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (accepted_total < issued_total) @(posedge clock);
      while (expected_responses.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
